### rtl/core/key_click_event_detector_unit_macros.svh
// Assertion macros for the key click event detector checker.
`ifndef KEY_CLICK_EVENT_DETECTOR_UNIT_MACROS_SVH
`define KEY_CLICK_EVENT_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KCED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KCED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/kced_pkg.sv
// Package with types, codes and constants of the key click event detector.
`timescale 1ns / 1ps
package kced_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int KEY_IDX_W    = 2;
  localparam int TICK_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CLICK_W      = 2;

  // Expiry holds while (now - deadline) mod 2^32 lies below this limit.
  localparam logic [TICK_W-1:0] EXPIRE_LIMIT = 32'h7FFF_FFFF;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd50;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] DOUBLE_CLICK_RST = 16'd400;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_CLICK = 2'd2;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_PRESSED  = 5'b00100,
    PH_DOUBLE   = 5'b01000,
    PH_LONG     = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_LONG    = 3'd2,
    EV_SHORT   = 3'd3,
    EV_DOUBLE  = 3'd4,
    EV_RELEASE = 3'd5
  } event_t;

  typedef struct packed {
    phase_t              phase;
    logic [TICK_W-1:0]   deadline;
    logic                armed;
    logic [CLICK_W-1:0]  clicks;
  } key_state_t;

  localparam key_state_t KEY_STATE_RST = '{
    phase:    PH_IDLE,
    deadline: '0,
    armed:    1'b0,
    clicks:   '0
  };

  typedef struct packed {
    logic [CFG_DATA_W-1:0] debounce;
    logic [CFG_DATA_W-1:0] long_press;
    logic [CFG_DATA_W-1:0] double_click;
  } cfg_t;

  typedef struct packed {
    key_state_t nxt;
    event_t     ev;
  } step_t;

endpackage

### rtl/core/kced_cfg_regs.sv
// Configuration registers for the debounce, long-press and double-click intervals.
`timescale 1ns / 1ps
module kced_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [kced_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [kced_pkg::CFG_DATA_W-1:0] wr_data,
  output kced_pkg::cfg_t                  cfg
);
  import kced_pkg::*;

  cfg_t cfg_r;

  // Writes to an index past the register list fall through and are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce     <= DEBOUNCE_RST;
      cfg_r.long_press   <= LONG_PRESS_RST;
      cfg_r.double_click <= DOUBLE_CLICK_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_DEBOUNCE:     cfg_r.debounce     <= wr_data;
        CFG_LONG_PRESS:   cfg_r.long_press   <= wr_data;
        CFG_DOUBLE_CLICK: cfg_r.double_click <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/kced_state_mem.sv
// Per-key state memory with registered read, valid bits and write forwarding.
`timescale 1ns / 1ps
module kced_state_mem #(
  parameter int NUM_KEYS = kced_pkg::NUM_KEYS_DEF,
  parameter int ADDR_W   = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rd_en,
  input  logic [ADDR_W-1:0]      rd_addr,
  input  logic                   wr_en,
  input  logic [ADDR_W-1:0]      wr_addr,
  input  kced_pkg::key_state_t   wr_data,
  output kced_pkg::key_state_t   rd_data
);
  import kced_pkg::*;

  key_state_t               mem_r [NUM_KEYS];
  logic [NUM_KEYS-1:0]      valid_r;
  key_state_t               rd_q_r;
  logic                     rd_vld_r;
  logic [ADDR_W-1:0]        rd_addr_r;
  key_state_t               fwd_data_r;
  logic [ADDR_W-1:0]        fwd_addr_r;
  logic                     fwd_vld_r;

  // Storage array: read-before-write, one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r    <= mem_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (wr_en) begin
      fwd_data_r <= wr_data;
      fwd_addr_r <= wr_addr;
    end
  end

  // Entries never written read as the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
        fwd_vld_r        <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  // The forward register always holds the newest write, so a match on it
  // is at least as fresh as the array word, and covers a write that landed
  // on the same edge as the read.
  always_comb begin
    if (fwd_vld_r && (fwd_addr_r == rd_addr_r)) begin
      rd_data = fwd_data_r;
    end else if (rd_vld_r) begin
      rd_data = rd_q_r;
    end else begin
      rd_data = KEY_STATE_RST;
    end
  end

endmodule

### rtl/core/kced_fsm.sv
// Next-state and event logic for one key scan sample.
`timescale 1ns / 1ps
module kced_fsm (
  input  kced_pkg::key_state_t            cur,
  input  logic                            held,
  input  logic [kced_pkg::TICK_W-1:0]     now,
  input  kced_pkg::cfg_t                  cfg,
  output kced_pkg::step_t                 step
);
  import kced_pkg::*;

  logic [TICK_W-1:0]     diff;
  logic                  expired;
  logic [CFG_DATA_W-1:0] interval;
  logic [TICK_W-1:0]     arm_tick;

  assign diff    = now - cur.deadline;
  assign expired = cur.armed && (diff < EXPIRE_LIMIT);

  // The interval armed in each phase is fixed, so the add runs beside the compare.
  always_comb begin
    case (cur.phase)
      PH_DEBOUNCE: interval = cfg.long_press;
      PH_PRESSED:  interval = cfg.double_click;
      default:     interval = cfg.debounce;
    endcase
  end

  assign arm_tick = now + {{(TICK_W-CFG_DATA_W){1'b0}}, interval};

  always_comb begin
    step.nxt = cur;
    step.ev  = EV_NONE;
    case (cur.phase)
      PH_IDLE: begin
        step.nxt.clicks = '0;
        if (held) begin
          step.nxt.phase    = PH_DEBOUNCE;
          step.nxt.deadline = arm_tick;
          step.nxt.armed    = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        if (expired) begin
          step.ev           = EV_PRESS;
          step.nxt.phase    = PH_PRESSED;
          step.nxt.deadline = arm_tick;
          step.nxt.armed    = 1'b1;
        end else if (!held) begin
          step.nxt.phase = PH_IDLE;
        end
      end
      PH_PRESSED: begin
        if (expired) begin
          step.ev        = EV_LONG;
          step.nxt.phase = PH_LONG;
          step.nxt.armed = 1'b0;
        end else if (!held) begin
          step.nxt.phase    = PH_DOUBLE;
          step.nxt.deadline = arm_tick;
          step.nxt.armed    = 1'b1;
        end
      end
      PH_DOUBLE: begin
        if (!expired) begin
          if (cur.clicks == CLICK_W'(1)) begin
            step.ev         = EV_DOUBLE;
            step.nxt.clicks = '0;
            step.nxt.phase  = PH_IDLE;
          end
          if (held) begin
            step.nxt.phase    = PH_DEBOUNCE;
            step.nxt.deadline = arm_tick;
            step.nxt.armed    = 1'b1;
            step.nxt.clicks   = step.nxt.clicks + CLICK_W'(1);
          end
        end else begin
          step.nxt.armed = 1'b0;
          if (!held) begin
            step.ev         = EV_SHORT;
            step.nxt.phase  = PH_IDLE;
            step.nxt.clicks = '0;
          end
        end
      end
      PH_LONG: begin
        if (!held) begin
          step.ev        = EV_RELEASE;
          step.nxt.phase = PH_IDLE;
        end
      end
      default: ;
    endcase
  end

endmodule

### rtl/core/key_click_event_detector_unit.sv
// Top level of the key click event detector: pipeline control and output register.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_ready): one transaction is one scan sample of one
//   key: in_key_index, in_pressed and the free-running tick in_now_tick.
//   Output channel (out_valid / out_ready): exactly one transaction per input
//   transaction, in order, carrying out_key_id, out_event_code and out_event_valid.
//   Configuration channel (cfg_valid / cfg_ready): writes the debounce, long-press
//   and double-click intervals by index; cfg_ready is always high. Write it only
//   while the block is idle. Indexes past the register list are ignored.
// Pipeline and throughput
//   The accepting edge starts the registered read of the per-key state memory and
//   loads the middle stage; once the output register is free, the state update is
//   loaded into the output register, from which the result is taken. One transaction
//   is taken per cycle while out_ready keeps the output draining; the rate is set by
//   the single read and single write port of the state memory, with the write of
//   one sample forwarded to the read of the next when both hit the same key.
// Reset and stall
//   Synchronous active-low reset restores the interval registers and clears the
//   state memory's valid bits, so every key starts idle with no timer running.
//   When out_ready stays low the output register and the middle stage fill up and
//   in_ready drops; nothing is lost or repeated.
module key_click_event_detector_unit #(
  parameter int NUM_KEYS = kced_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [kced_pkg::KEY_IDX_W-1:0]  in_key_index,
  input  logic                            in_pressed,
  input  logic [kced_pkg::TICK_W-1:0]     in_now_tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [kced_pkg::KEY_IDX_W-1:0]  out_key_id,
  output logic [2:0]                      out_event_code,
  output logic                            out_event_valid,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [kced_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kced_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kced_pkg::*;

  localparam int ADDR_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  cfg_t                cfg;
  key_state_t          cur_state;
  step_t               step;

  // Middle stage: the sample whose key state is being read from memory.
  logic                s1_vld_r;
  logic [KEY_IDX_W-1:0] s1_key_r;
  logic                s1_held_r;
  logic [TICK_W-1:0]   s1_now_r;
  logic                s1_inr_r;

  // Output register.
  logic                out_vld_r;
  logic [KEY_IDX_W-1:0] out_key_r;
  event_t              out_ev_r;

  logic                out_free;
  logic                s1_adv;
  logic                in_acc;
  logic                in_range;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  event_t              ev_nxt;

  // The output register frees up when it is empty or being drained this cycle.
  assign out_free = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_free;
  assign in_ready = !s1_vld_r || out_free;
  assign in_acc   = in_valid && in_ready;

  // Samples for keys beyond the configured count leave the state untouched.
  assign in_range = (32'(in_key_index) < NUM_KEYS);
  assign rd_addr  = ADDR_W'(in_key_index);
  assign wr_addr  = ADDR_W'(s1_key_r);

  assign cfg_ready = 1'b1;

  kced_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kced_state_mem #(
    .NUM_KEYS (NUM_KEYS),
    .ADDR_W   (ADDR_W)
  ) u_state_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (rd_addr),
    .wr_en   (s1_adv && s1_inr_r),
    .wr_addr (wr_addr),
    .wr_data (step.nxt),
    .rd_data (cur_state)
  );

  kced_fsm u_fsm (
    .cur  (cur_state),
    .held (s1_held_r),
    .now  (s1_now_r),
    .cfg  (cfg),
    .step (step)
  );

  assign ev_nxt = s1_inr_r ? step.ev : EV_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r  <= in_key_index;
      s1_held_r <= in_pressed;
      s1_now_r  <= in_now_tick;
      s1_inr_r  <= in_range;
    end
    if (s1_adv) begin
      out_key_r <= s1_key_r;
      out_ev_r  <= ev_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_key_id      = out_key_r;
  assign out_event_code  = out_ev_r;
  assign out_event_valid = (out_ev_r != EV_NONE);

endmodule

### rtl/core/kced_checker.sv
// Port-level checker for the key click event detector, bound to the top level.
`timescale 1ns / 1ps
`include "key_click_event_detector_unit_macros.svh"
module kced_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [kced_pkg::KEY_IDX_W-1:0]  out_key_id,
  input logic [2:0]                      out_event_code,
  input logic                            out_event_valid
);
  import kced_pkg::*;

  // A stalled result keeps its payload.
  `KCED_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_key_id) && $stable(out_event_code)
    && $stable(out_event_valid), "result changed while stalled")

  // The valid flag of an event agrees with its code.
  `KCED_ASSERT_NOW(a_event_flag, clk, rst_n, out_valid,
    out_event_valid == (out_event_code != EV_NONE), "event_valid disagrees with code")

  // With the output register empty the input side is never blocked.
  `KCED_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid,
    in_ready, "input stalled with empty output")

  // No result appears in the cycle right after reset is released.
  `KCED_ASSERT_NOW(a_quiet_after_reset, clk, rst_n, $past(!rst_n),
    !out_valid, "result visible right after reset")

endmodule

bind key_click_event_detector_unit kced_checker u_kced_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_key_id      (out_key_id),
  .out_event_code  (out_event_code),
  .out_event_valid (out_event_valid)
);
